@@ rtl/tfwd_pkg.sv @@
// ----------------------------------------------------------------------------
// tfwd_pkg
// Shared types and codes for the two-queue weighted drain block.
// ----------------------------------------------------------------------------
package tfwd_pkg;

  localparam int VALUE_W = 31;

  // cmd codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kind codes
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_SERVED = 2'd1;
  localparam logic [1:0] KIND_IDLE   = 2'd2;

  // queue ids
  localparam logic QUEUE_A = 1'b0;
  localparam logic QUEUE_B = 1'b1;

  // result select codes from controller to datapath
  localparam logic [1:0] SEL_PUSH = 2'd0;
  localparam logic [1:0] SEL_A    = 2'd1;
  localparam logic [1:0] SEL_B    = 2'd2;
  localparam logic [1:0] SEL_IDLE = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] served_value;
    logic               source_queue;
    logic               accepted;
    logic               both_empty;
    logic               last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;    // capture request
    logic       push;    // store captured value
    logic       pop_a;
    logic       pop_b;
    logic       toggle;  // advance tick parity
    logic       emit;    // load result register
    logic [1:0] sel;
    logic       last;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic a_has;   // queue A non-empty
    logic b_due;   // this tick is even and queue B non-empty
  } stat_t;

endpackage

@@ rtl/two_fifo_weighted_drain.sv @@
// ----------------------------------------------------------------------------
// two_fifo_weighted_drain
// Two circular queues drained 2:1. Pushes route odd values to queue A and
// even values to queue B; each tick serves A, and every second tick also B.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload   notes
//  -------   ----------------   -------   ---------------------------------
//  request   start / busy       item      taken when start && !busy
//  result    strobe             result    one-cycle strobe per result, no stall
//
//  Sequence: a push runs the accept step, then the exec step. A tick does
//  the same, with a B-pop step after exec when it serves both queues, since
//  both results leave through the one result register, one per cycle.
//  Results appear in the cycle after the step that made them; the next
//  request can be taken in that same cycle.
//  Reset (rst, synchronous) clears pointers, counts, tick parity and the
//  sequencer; queue storage is not cleared, and no clearing pass runs.
//  The receiver cannot stall: each result is valid for its strobe cycle only.
// ----------------------------------------------------------------------------
module two_fifo_weighted_drain #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tfwd_pkg::in_t  item,
  output logic           strobe,
  output tfwd_pkg::out_t result
);

  tfwd_pkg::ctl_t  ctl;
  tfwd_pkg::stat_t stat;

  // sequencer: idle -> exec (push or first tick result) -> optional B pop
  tfwd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // queues, parity and the registered result
  tfwd_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

  // a non-final result is always followed at once by the rest of the request
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("second result of a tick did not follow");

  // push status is always a single result
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == tfwd_pkg::KIND_PUSH |-> result.last)
    else $error("push status not marked last");

  // the cycle after a request is taken carries no result
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("result overlapped request execution");

  // a multi-result request always ends with a queue B service
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> result.source_queue == tfwd_pkg::QUEUE_B)
    else $error("second result not from queue B");

endmodule

@@ rtl/tfwd_queue.sv @@
// ----------------------------------------------------------------------------
// tfwd_queue
// Circular FIFO with full-capacity count and a registered read of the head.
// ----------------------------------------------------------------------------
module tfwd_queue #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         pop,
  input  logic [tfwd_pkg::VALUE_W-1:0] wdata,
  output logic [tfwd_pkg::VALUE_W-1:0] rdata,
  output logic                         empty,
  output logic                         full,
  output logic                         empty_next
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [tfwd_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          do_push;
  logic          do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + CW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CW'(1);
    end
  end

  assign empty_next = (count_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        tail <= (tail == IW'(DEPTH - 1)) ? '0 : tail + IW'(1);
      end
      if (do_pop) begin
        head <= (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);
      end
    end
  end

  // storage: no reset, entries are defined once written
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= wdata;
    end
    rdata <= mem[head];
  end

endmodule

@@ rtl/tfwd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfwd_ctrl
// Sequencer: takes a request, runs push or tick steps, orders the results.
// ----------------------------------------------------------------------------
module tfwd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tfwd_pkg::stat_t stat,
  output tfwd_pkg::ctl_t  ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_POPB = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.sel    = tfwd_pkg::SEL_IDLE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // first exec cycle; a tick request branches here
        if (stat.is_tick) begin
          ctl.toggle = 1'b1;
          ctl.emit   = 1'b1;
          state_next = ST_IDLE;
          if (stat.a_has) begin
            ctl.pop_a = 1'b1;
            ctl.sel   = tfwd_pkg::SEL_A;
            ctl.last  = !stat.b_due;
            if (stat.b_due) begin
              state_next = ST_POPB;
            end
          end else if (stat.b_due) begin
            ctl.pop_b = 1'b1;
            ctl.sel   = tfwd_pkg::SEL_B;
            ctl.last  = 1'b1;
          end else begin
            ctl.sel  = tfwd_pkg::SEL_IDLE;
            ctl.last = 1'b1;
          end
        end else begin
          ctl.push   = 1'b1;
          ctl.emit   = 1'b1;
          ctl.sel    = tfwd_pkg::SEL_PUSH;
          ctl.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        // not entered; kept as a safe return path
        state_next = ST_IDLE;
      end
      ST_POPB: begin
        ctl.pop_b  = 1'b1;
        ctl.emit   = 1'b1;
        ctl.sel    = tfwd_pkg::SEL_B;
        ctl.last   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/tfwd_dpath.sv @@
// ----------------------------------------------------------------------------
// tfwd_dpath
// Request register, the two queues, tick parity and the result register.
// ----------------------------------------------------------------------------
module tfwd_dpath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  tfwd_pkg::in_t   item,
  input  tfwd_pkg::ctl_t  ctl,
  output tfwd_pkg::stat_t stat,
  output logic            strobe,
  output tfwd_pkg::out_t  result
);

  tfwd_pkg::in_t  req;
  tfwd_pkg::out_t res_next;
  logic           parity;
  logic           to_a;
  logic           push_a, push_b;
  logic [tfwd_pkg::VALUE_W-1:0] rdata_a, rdata_b;
  logic           empty_a, empty_b, full_a, full_b;
  logic           empty_next_a, empty_next_b;

  // odd values go to queue A
  assign to_a   = req.value[0];
  assign push_a = ctl.push && to_a && !full_a;
  assign push_b = ctl.push && !to_a && !full_b;

  tfwd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_a (
    .clk        (clk),
    .rst        (rst),
    .push       (push_a),
    .pop        (ctl.pop_a),
    .wdata      (req.value),
    .rdata      (rdata_a),
    .empty      (empty_a),
    .full       (full_a),
    .empty_next (empty_next_a)
  );

  tfwd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_b (
    .clk        (clk),
    .rst        (rst),
    .push       (push_b),
    .pop        (ctl.pop_b),
    .wdata      (req.value),
    .rdata      (rdata_b),
    .empty      (empty_b),
    .full       (full_b),
    .empty_next (empty_next_b)
  );

  // tick is even when parity returns to 0, i.e. it is 1 now
  assign stat.is_tick = (req.cmd == tfwd_pkg::CMD_TICK);
  assign stat.a_has   = !empty_a;
  assign stat.b_due   = parity && !empty_b;

  always_comb begin
    res_next            = '0;
    res_next.both_empty = empty_next_a && empty_next_b;
    res_next.last       = ctl.last;
    case (ctl.sel)
      tfwd_pkg::SEL_PUSH: begin
        res_next.kind         = tfwd_pkg::KIND_PUSH;
        res_next.source_queue = to_a ? tfwd_pkg::QUEUE_A : tfwd_pkg::QUEUE_B;
        res_next.accepted     = push_a || push_b;
      end
      tfwd_pkg::SEL_A: begin
        res_next.kind         = tfwd_pkg::KIND_SERVED;
        res_next.served_value = rdata_a;
        res_next.source_queue = tfwd_pkg::QUEUE_A;
      end
      tfwd_pkg::SEL_B: begin
        res_next.kind         = tfwd_pkg::KIND_SERVED;
        res_next.served_value = rdata_b;
        res_next.source_queue = tfwd_pkg::QUEUE_B;
      end
      default: begin
        res_next.kind = tfwd_pkg::KIND_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
      if (ctl.toggle) begin
        parity <= !parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req <= item;
    end
    if (ctl.emit) begin
      result <= res_next;
    end
  end

endmodule

@@ dv/two_fifo_weighted_drain_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_fifo_weighted_drain_tb
// Self-checking bench for the 2:1 weighted two-queue drain. Requests are
// queued by a stimulus process, driven on the falling edge and predicted
// when taken. Every result strobe is checked field by field against the
// oldest predicted result. Three sender pacing phases; random sequences
// fill queues to overflow, drain them and mix both.
// ----------------------------------------------------------------------------
module two_fifo_weighted_drain_tb;

  localparam int DEPTH    = 64;
  localparam int PHASE_N  = 550;   // minimum random requests per pacing phase

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tfwd_pkg::in_t  item = '0;
  logic strobe;
  tfwd_pkg::out_t result;

  two_fifo_weighted_drain #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  tfwd_pkg::in_t  req_backlog[$];   // requests waiting to be driven
  tfwd_pkg::out_t due_results[$];   // predicted results, oldest first
  bit   req_taken = 1'b0; // request handshake completed at the last rising edge
  int   idle_pct = 7;     // chance (percent) that the sender holds start low

  int   n_errors = 0;
  int   n_taken = 0;
  int   n_results = 0;
  int   n_drops = 0;
  int   n_idle_ticks = 0;
  int   n_pair_ticks = 0;

  // Shadow of the two queues; only pushed slots are ever popped.
  logic [tfwd_pkg::VALUE_W-1:0] odd_mem[DEPTH];
  logic [tfwd_pkg::VALUE_W-1:0] even_mem[DEPTH];
  int   odd_head = 0, odd_cnt = 0;
  int   even_head = 0, even_cnt = 0;
  logic tick_phase = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Predictor: updates the shadow queues for one taken request and appends
  // the results it must produce. both_empty is taken after each single pop,
  // so the A result of a paired tick still sees B non-empty.
  // --------------------------------------------------------------------------
  task automatic drain_step(input tfwd_pkg::in_t req);
    tfwd_pkg::out_t r;
    logic b_due;
    bit   served;
    served = 1'b0;
    if (req.cmd == tfwd_pkg::CMD_PUSH) begin
      r = '0;
      r.kind = tfwd_pkg::KIND_PUSH;
      r.last = 1'b1;
      if (req.value[0]) begin
        r.source_queue = tfwd_pkg::QUEUE_A;
        if (odd_cnt < DEPTH) begin
          odd_mem[(odd_head + odd_cnt) % DEPTH] = req.value;
          odd_cnt++;
          r.accepted = 1'b1;
        end
      end else begin
        r.source_queue = tfwd_pkg::QUEUE_B;
        if (even_cnt < DEPTH) begin
          even_mem[(even_head + even_cnt) % DEPTH] = req.value;
          even_cnt++;
          r.accepted = 1'b1;
        end
      end
      if (!r.accepted) n_drops++;
      r.both_empty = (odd_cnt == 0) && (even_cnt == 0);
      due_results.push_back(r);
    end else begin
      // parity flips on every tick, served or not; B only on even ticks
      tick_phase = ~tick_phase;
      b_due = (tick_phase == 1'b0) && (even_cnt != 0);
      if (odd_cnt != 0) begin
        r = '0;
        r.kind = tfwd_pkg::KIND_SERVED;
        r.served_value = odd_mem[odd_head];
        r.source_queue = tfwd_pkg::QUEUE_A;
        odd_head = (odd_head + 1) % DEPTH;
        odd_cnt--;
        r.last = !b_due;
        r.both_empty = (odd_cnt == 0) && (even_cnt == 0);
        due_results.push_back(r);
        served = 1'b1;
      end
      if (b_due) begin
        r = '0;
        r.kind = tfwd_pkg::KIND_SERVED;
        r.served_value = even_mem[even_head];
        r.source_queue = tfwd_pkg::QUEUE_B;
        even_head = (even_head + 1) % DEPTH;
        even_cnt--;
        r.last = 1'b1;
        r.both_empty = (odd_cnt == 0) && (even_cnt == 0);
        due_results.push_back(r);
        if (served) n_pair_ticks++;
        served = 1'b1;
      end
      if (!served) begin
        // nothing to serve (A empty, and B empty or odd tick)
        r = '0;
        r.kind = tfwd_pkg::KIND_IDLE;
        r.last = 1'b1;
        r.both_empty = (odd_cnt == 0) && (even_cnt == 0);
        due_results.push_back(r);
        n_idle_ticks++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: changes start/item on the falling edge only. A request leaves
  // the backlog once the rising edge saw start && !busy.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
    end else begin
      if (req_taken) void'(req_backlog.pop_front());
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        item  <= req_backlog[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, first check any result leaving the block
  // (it belongs to an earlier request), then predict a request taken now.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      if (strobe) begin
        n_results++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(result.kind), '0);
        end else begin
          if (result.kind != due_results[0].kind)
            report_mismatch("kind", 32'(result.kind), 32'(due_results[0].kind));
          if (result.served_value != due_results[0].served_value)
            report_mismatch("served_value", 32'(result.served_value),
                            32'(due_results[0].served_value));
          if (result.source_queue != due_results[0].source_queue)
            report_mismatch("source_queue", 32'(result.source_queue),
                            32'(due_results[0].source_queue));
          if (result.accepted != due_results[0].accepted)
            report_mismatch("accepted", 32'(result.accepted),
                            32'(due_results[0].accepted));
          if (result.both_empty != due_results[0].both_empty)
            report_mismatch("both_empty", 32'(result.both_empty),
                            32'(due_results[0].both_empty));
          if (result.last != due_results[0].last)
            report_mismatch("last", 32'(result.last), 32'(due_results[0].last));
          void'(due_results.pop_front());
        end
      end
      if (start && !busy) begin
        drain_step(item);
        req_taken = 1'b1;
        n_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Value of a given parity; extremes show up often so the top and bottom
  // bits see both levels.
  function automatic logic [tfwd_pkg::VALUE_W-1:0] pick_value(input bit want_odd);
    logic [tfwd_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '1;
      1:       v = '0;
      2:       v = tfwd_pkg::VALUE_W'($urandom_range(0, 15));
      3:       v = {1'b1, (tfwd_pkg::VALUE_W-1)'($urandom)};
      default: v = tfwd_pkg::VALUE_W'($urandom);
    endcase
    v[0] = want_odd;
    return v;
  endfunction

  function automatic tfwd_pkg::in_t push_req(input logic [tfwd_pkg::VALUE_W-1:0] v);
    tfwd_pkg::in_t r;
    r.cmd   = tfwd_pkg::CMD_PUSH;
    r.value = v;
    return r;
  endfunction

  // value field is ignored on a tick, but still toggled
  function automatic tfwd_pkg::in_t tick_req();
    tfwd_pkg::in_t r;
    r.cmd   = tfwd_pkg::CMD_TICK;
    r.value = tfwd_pkg::VALUE_W'($urandom);
    return r;
  endfunction

  // Random bursts: long same-parity fills that overflow a queue, long
  // drains, mixed traffic, and a little raw noise.
  task automatic queue_random(input int count);
    int  made, len;
    bit  par;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          par = 1'($urandom_range(0, 1));
          len = $urandom_range(40, 80);
          repeat (len) req_backlog.push_back(push_req(pick_value(par)));
        end
        3, 4: begin
          len = $urandom_range(10, 80);
          repeat (len) req_backlog.push_back(tick_req());
        end
        5, 6, 7, 8: begin
          len = $urandom_range(10, 40);
          repeat (len) begin
            if ($urandom_range(0, 99) < 55)
              req_backlog.push_back(push_req(pick_value(1'($urandom_range(0, 1)))));
            else
              req_backlog.push_back(tick_req());
          end
        end
        default: begin
          len = $urandom_range(5, 20);
          repeat (len) begin
            tfwd_pkg::in_t r;
            r.cmd   = 1'($urandom_range(0, 1));
            r.value = tfwd_pkg::VALUE_W'($urandom);
            req_backlog.push_back(r);
          end
        end
      endcase
      made += len;
    end
  endtask

  task automatic wait_backlog_empty();
    while (req_backlog.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int settle;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ticks on empty queues (parity still advances), extreme
    // values into both queues, an odd tick with only B loaded (idle), a
    // paired tick, an even tick serving B alone.
    req_backlog.push_back(tick_req());
    req_backlog.push_back(tick_req());
    req_backlog.push_back(tick_req());
    req_backlog.push_back(tick_req());      // even again, both empty
    req_backlog.push_back(push_req('0));
    req_backlog.push_back(push_req(31'h7FFF_FFFE));
    req_backlog.push_back(push_req(31'h0000_0001));
    req_backlog.push_back(push_req(31'h7FFF_FFFF));
    req_backlog.push_back(tick_req());      // odd: A only
    req_backlog.push_back(tick_req());      // even: A then B
    req_backlog.push_back(tick_req());      // odd: A empty, B waits -> idle
    req_backlog.push_back(tick_req());      // even: B only
    req_backlog.push_back(tick_req());      // odd, all empty -> idle
    req_backlog.push_back(push_req(31'h5555_5555));
    req_backlog.push_back(push_req(31'h2AAA_AAAA));
    req_backlog.push_back(tick_req());      // even: pair, queues drain to empty

    // Pacing: light sender gaps, then heavy, then none.
    idle_pct = 7;
    queue_random(PHASE_N);
    wait_backlog_empty();
    idle_pct = 66;
    queue_random(PHASE_N);
    wait_backlog_empty();
    idle_pct = 0;
    queue_random(PHASE_N);
    wait_backlog_empty();

    // Let outstanding results drain, then keep watching to catch any extras.
    settle = 0;
    while (due_results.size() != 0 && settle < 1000) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      report_mismatch("predicted results never appeared", 32'(due_results.size()), '0);
    end

    $display("Covered %0d requests, %0d results: %0d drops on full queues,",
             n_taken, n_results, n_drops);
    $display("  %0d idle ticks, %0d ticks serving both queues, %0d mismatches.",
             n_idle_ticks, n_pair_ticks, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: stimulus or results stalled");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
